### design/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants for the sorted free-list allocator
// Field widths, status codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int BLOCK_W = 10;
    localparam int STAT_W  = 2;
    localparam int BLOCK_COUNT_DEF = 1024;

    // free count saturates at the largest value the field holds
    localparam logic [BLOCK_W-1:0] FREE_MAX = '1;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALREADY = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic load;        // latch accepted request
        logic alloc_rd;    // read link of head
        logic alloc_fin;   // pop head, grant it
        logic res_empty;
        logic res_invalid;
        logic res_already;
        logic res_ok;      // walk cap hit, no change
        logic walk_init;
        logic walk_step;
        logic ins_wr;      // link new block to its successor
        logic ins_link;    // link predecessor (or head) to new block
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic head_zero;
        logic blk_invalid;
        logic walk_more;
        logic cur_eq_blk;
        logic cap_hit;
        logic out_free;
    } t_dp_stat;

endpackage

### design/sfla_if.sv
// ----------------------------------------------------------------------------
// sfla_if: request and response channels of the allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sfla_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [sfla_pkg::BLOCK_W-1:0] block;

    modport source (output valid, output func, output block, input ready);
    modport sink   (input valid, input func, input block, output ready);
endinterface

interface sfla_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sfla_pkg::BLOCK_W-1:0] granted_block;
    logic [sfla_pkg::STAT_W-1:0]  status;
    logic [sfla_pkg::BLOCK_W-1:0] free_total;

    modport source (output valid, output granted_block, output status,
                    output free_total, input ready);
    modport sink   (input valid, input granted_block, input status,
                    input free_total, output ready);
endinterface

### design/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl: request sequencer
// Dispatches allocate and free requests and steps the list walk.
// ----------------------------------------------------------------------------
module sfla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sfla_pkg::t_dp_stat i_stat,
    output sfla_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DISPATCH   = 3'd1;
    localparam logic [2:0] S_ALLOC_WAIT = 3'd2;
    localparam logic [2:0] S_WALK       = 3'd3;
    localparam logic [2:0] S_LINK       = 3'd4;
    localparam logic [2:0] S_OUT        = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.func == sfla_pkg::FN_ALLOC) begin
                    if (i_stat.head_zero) begin
                        o_cmd.res_empty = 1'b1;
                        n_state         = S_OUT;
                    end else begin
                        o_cmd.alloc_rd = 1'b1;
                        n_state        = S_ALLOC_WAIT;
                    end
                end else if (i_stat.blk_invalid) begin
                    o_cmd.res_invalid = 1'b1;
                    n_state           = S_OUT;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_ALLOC_WAIT: begin
                o_cmd.alloc_fin = 1'b1;
                n_state         = S_OUT;
            end
            S_WALK: begin
                if (i_stat.walk_more) begin
                    if (i_stat.cap_hit) begin
                        o_cmd.res_ok = 1'b1;
                        n_state      = S_OUT;
                    end else begin
                        o_cmd.walk_step = 1'b1;
                    end
                end else if (i_stat.cur_eq_blk) begin
                    o_cmd.res_already = 1'b1;
                    n_state           = S_OUT;
                end else begin
                    o_cmd.ins_wr = 1'b1;
                    n_state      = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.ins_link = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/sfla_dp.sv
// ----------------------------------------------------------------------------
// sfla_dp: allocator datapath
// Link table memory, head and count registers, walk cursor, result register.
// ----------------------------------------------------------------------------
module sfla_dp #(
    parameter int BLOCK_COUNT = sfla_pkg::BLOCK_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfla_pkg::t_dp_cmd            i_cmd,
    output sfla_pkg::t_dp_stat           o_stat,
    input  logic                         i_func,
    input  logic [sfla_pkg::BLOCK_W-1:0] i_block,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [sfla_pkg::BLOCK_W-1:0] o_granted_block,
    output logic [sfla_pkg::STAT_W-1:0]  o_status,
    output logic [sfla_pkg::BLOCK_W-1:0] o_free_total
);

    localparam int ADDR_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int STEP_W = $clog2(BLOCK_COUNT + 1);
    localparam int EXT_W  = 17;
    localparam int BW     = sfla_pkg::BLOCK_W;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [BW-1:0] b);
        logic [EXT_W-1:0] ext;
        ext = {{(EXT_W-BW){1'b0}}, b};
        return ext[ADDR_W-1:0];
    endfunction

    logic [BW-1:0]     r_mem [BLOCK_COUNT];
    logic [BW-1:0]     r_rd;

    logic              r_func;
    logic [BW-1:0]     r_blk;
    logic [BW-1:0]     r_head;
    logic [BW-1:0]     r_count;
    logic [BW-1:0]     r_cur;
    logic [BW-1:0]     r_prev;
    logic [STEP_W-1:0] r_steps;
    logic              r_from_mem;

    logic [BW-1:0]               r_res_gb;
    logic [sfla_pkg::STAT_W-1:0] r_res_st;

    logic                        r_o_valid;
    logic [BW-1:0]               r_o_gb;
    logic [sfla_pkg::STAT_W-1:0] r_o_st;
    logic [BW-1:0]               r_o_ft;

    logic [BW-1:0]     cur_w;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [BW-1:0]     mem_wd;
    logic [EXT_W-1:0]  blk_ext;

    // walk cursor comes straight from the table output after a step
    assign cur_w   = r_from_mem ? r_rd : r_cur;
    assign blk_ext = {{(EXT_W-BW){1'b0}}, r_blk};

    assign mem_re = i_cmd.alloc_rd | i_cmd.walk_step;
    assign mem_ra = i_cmd.alloc_rd ? to_addr(r_head) : to_addr(cur_w);
    assign mem_we = i_cmd.ins_wr | (i_cmd.ins_link & (r_prev != '0));
    assign mem_wa = i_cmd.ins_wr ? to_addr(r_blk) : to_addr(r_prev);
    assign mem_wd = i_cmd.ins_wr ? cur_w : r_blk;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    assign o_stat.func        = r_func;
    assign o_stat.head_zero   = (r_head == '0);
    assign o_stat.blk_invalid = (r_blk == '0) || (blk_ext >= EXT_W'(BLOCK_COUNT));
    assign o_stat.walk_more   = (cur_w != '0) && (cur_w < r_blk);
    assign o_stat.cur_eq_blk  = (cur_w == r_blk);
    assign o_stat.cap_hit     = (r_steps >= STEP_W'(BLOCK_COUNT));
    assign o_stat.out_free    = !r_o_valid || i_out_ready;

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_blk  <= i_block;
        end
        if (i_cmd.walk_init) begin
            r_cur   <= r_head;
            r_prev  <= '0;
            r_steps <= '0;
        end
        if (i_cmd.walk_step) begin
            r_prev  <= cur_w;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.ins_wr) begin
            r_cur <= cur_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_from_mem <= 1'b0;
        end else if (i_cmd.walk_init || i_cmd.ins_wr) begin
            r_from_mem <= 1'b0;
        end else if (i_cmd.walk_step) begin
            r_from_mem <= 1'b1;
        end
    end

    // list head and free count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.alloc_fin) begin
            r_head <= r_rd;
            if (r_count != '0) begin
                r_count <= r_count - 1'b1;
            end
        end else if (i_cmd.ins_link) begin
            if (r_prev == '0) begin
                r_head <= r_blk;
            end
            if (r_count != sfla_pkg::FREE_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.alloc_fin) begin
            r_res_gb <= r_head;
            r_res_st <= sfla_pkg::ST_OK;
        end else if (i_cmd.res_empty) begin
            r_res_gb <= '0;
            r_res_st <= sfla_pkg::ST_EMPTY;
        end else if (i_cmd.res_invalid) begin
            r_res_gb <= '0;
            r_res_st <= sfla_pkg::ST_INVALID;
        end else if (i_cmd.res_already) begin
            r_res_gb <= '0;
            r_res_st <= sfla_pkg::ST_ALREADY;
        end else if (i_cmd.res_ok || i_cmd.ins_link) begin
            r_res_gb <= '0;
            r_res_st <= sfla_pkg::ST_OK;
        end else begin
            r_res_gb <= r_res_gb;
            r_res_st <= r_res_st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_gb <= r_res_gb;
            r_o_st <= r_res_st;
            r_o_ft <= r_count;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_granted_block = r_o_gb;
    assign o_status        = r_o_st;
    assign o_free_total    = r_o_ft;

endmodule

### design/sorted_free_list_block_allocator.sv
// Allocate: the head's link is read, then the head is popped and granted; an empty
// list gets its status without a read. Free: the walk follows one link per cycle past
// the free blocks below the freed one, then links the block in; already free, block
// zero or out of range leave the list unchanged. One request in flight; a new one is
// taken the cycle after the result is registered, while it may still wait for ready.
// Reset clears head, free count and handshake state; the link table is not cleared.
// ----------------------------------------------------------------------------
// sorted_free_list_block_allocator: sorted free-list block allocator
// Pops the lowest free block on allocate, inserts in order on free.
// ----------------------------------------------------------------------------
module sorted_free_list_block_allocator #(
    parameter int BLOCK_COUNT = sfla_pkg::BLOCK_COUNT_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sfla_req_if.sink   i_req,
    sfla_rsp_if.source o_rsp
);

    sfla_pkg::t_dp_cmd  cmd;
    sfla_pkg::t_dp_stat stat;

    sfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sfla_dp #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_req.func),
        .i_block         (i_req.block),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_granted_block (o_rsp.granted_block),
        .o_status        (o_rsp.status),
        .o_free_total    (o_rsp.free_total)
    );

endmodule
